[hw/rtl/crt_pkg.sv]
// shared types, constants and the setting tables for the conductivity ratio trim
`timescale 1ns / 1ps
`default_nettype none
package crt_pkg;

    localparam logic [7:0] CODE_FIRST = 8'd120;
    localparam logic [7:0] CODE_LAST  = 8'd145;

    localparam logic [2:0] CFG_TARGET_CODE = 3'd0;
    localparam logic [2:0] CFG_MARGIN      = 3'd1;
    localparam logic [2:0] CFG_PERIOD      = 3'd2;
    localparam logic [2:0] CFG_DEADBAND    = 3'd3;
    localparam logic [2:0] CFG_WINDOW      = 3'd4;

    localparam logic [1:0] TREND_NEUTRAL = 2'd0;
    localparam logic [1:0] TREND_UP      = 2'd1;
    localparam logic [1:0] TREND_DOWN    = 2'd2;

    localparam logic [7:0] RATIO_MAX = 8'd255;

    typedef struct packed {
        logic        started;
        logic [7:0]  ratio;
        logic [7:0]  corr_cnt;
        logic [7:0]  win_cnt;
        logic [15:0] ref_sample;
        logic [1:0]  trend;
    } t_state;

    typedef struct packed {
        logic [7:0] target_code;
        logic [9:0] margin;
        logic [7:0] period;
        logic [7:0] deadband;
        logic [7:0] window;
    } t_cfg;

    typedef struct packed {
        logic [7:0] ratio;
        logic [1:0] trend;
        logic       bad_code;
    } t_result;

    function automatic logic [10:0] target_of(input logic [4:0] idx);
        logic [10:0] t;
        case (idx)
            5'd0:    t = 11'd1280;
            5'd1:    t = 11'd1290;
            5'd2:    t = 11'd1300;
            5'd3:    t = 11'd1310;
            5'd4:    t = 11'd1320;
            5'd5:    t = 11'd1330;
            5'd6:    t = 11'd1340;
            5'd7:    t = 11'd1350;
            5'd8:    t = 11'd1360;
            5'd9:    t = 11'd1370;
            5'd10:   t = 11'd1380;
            5'd11:   t = 11'd1390;
            5'd12:   t = 11'd1400;
            5'd13:   t = 11'd1420;
            5'd14:   t = 11'd1430;
            5'd15:   t = 11'd1440;
            5'd16:   t = 11'd1450;
            5'd17:   t = 11'd1458;
            5'd18:   t = 11'd1465;
            5'd19:   t = 11'd1475;
            5'd20:   t = 11'd1480;
            5'd21:   t = 11'd1483;
            5'd22:   t = 11'd1490;
            5'd23:   t = 11'd1495;
            5'd24:   t = 11'd1500;
            5'd25:   t = 11'd1505;
            default: t = 11'd0;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] base_of(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'd242;
            5'd1:    b = 8'd239;
            5'd2:    b = 8'd235;
            5'd3:    b = 8'd232;
            5'd4:    b = 8'd229;
            5'd5:    b = 8'd226;
            5'd6:    b = 8'd223;
            5'd7:    b = 8'd220;
            5'd8:    b = 8'd217;
            5'd9:    b = 8'd214;
            5'd10:   b = 8'd211;
            5'd11:   b = 8'd208;
            5'd12:   b = 8'd205;
            5'd13:   b = 8'd202;
            5'd14:   b = 8'd199;
            5'd15:   b = 8'd196;
            5'd16:   b = 8'd194;
            5'd17:   b = 8'd192;
            5'd18:   b = 8'd190;
            5'd19:   b = 8'd189;
            5'd20:   b = 8'd187;
            5'd21:   b = 8'd186;
            5'd22:   b = 8'd183;
            5'd23:   b = 8'd182;
            5'd24:   b = 8'd181;
            5'd25:   b = 8'd180;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/crt_core.sv]
// next-state and result logic for one conductivity sample
`timescale 1ns / 1ps
`default_nettype none
module crt_core
    import crt_pkg::*;
(
    input  wire t_state      i_state,
    input  wire t_cfg        i_cfg,
    input  wire logic [15:0] i_conductivity,
    output t_state           o_state,
    output t_result          o_result
);

    logic        code_ok;
    logic [4:0]  idx;
    logic [10:0] target;
    logic [7:0]  base;
    logic [7:0]  ratio0;
    logic        active;
    logic [7:0]  win_inc;
    logic [7:0]  corr_inc;
    logic [1:0]  trend_new;
    logic        step;
    logic        go_up;
    logic        go_down;
    logic [7:0]  ratio_s;
    logic [7:0]  ratio_f;
    t_state      st;

    assign code_ok  = (i_cfg.target_code >= CODE_FIRST) && (i_cfg.target_code <= CODE_LAST);
    assign idx      = 5'(i_cfg.target_code - CODE_FIRST);
    assign target   = target_of(idx);
    assign base     = base_of(idx);
    assign ratio0   = i_state.started ? i_state.ratio : base;
    assign active   = ({1'b0, i_conductivity} + 17'(i_cfg.margin)) > 17'(target);
    assign win_inc  = i_state.win_cnt + 8'd1;
    assign corr_inc = i_state.corr_cnt + 8'd1;
    assign step     = (corr_inc == i_cfg.period);

    always_comb begin
        if (i_state.ref_sample > i_conductivity) begin
            trend_new = TREND_UP;
        end else if (i_state.ref_sample < i_conductivity) begin
            trend_new = TREND_DOWN;
        end else begin
            trend_new = TREND_NEUTRAL;
        end
    end

    assign go_up   = (trend_new == TREND_UP)
                  && ({1'b0, i_conductivity} > (17'(target) + 17'(i_cfg.deadband)))
                  && (ratio0 != RATIO_MAX);
    assign go_down = (trend_new == TREND_DOWN)
                  && (({1'b0, i_conductivity} + 17'(i_cfg.deadband)) < 17'(target));

    always_comb begin
        if (step && go_up) begin
            ratio_s = ratio0 + 8'd1;
        end else if (step && go_down) begin
            ratio_s = ratio0 - 8'd1;
        end else begin
            ratio_s = ratio0;
        end
    end

    assign ratio_f = (ratio_s == 8'd0) ? base : ratio_s;

    always_comb begin
        st         = i_state;
        st.started = 1'b1;
        st.ratio   = ratio0;
        if (active) begin
            st.trend    = trend_new;
            st.win_cnt  = (win_inc >= i_cfg.window) ? 8'd0 : win_inc;
            if (win_inc >= i_cfg.window) begin
                st.ref_sample = i_conductivity;
            end
            st.corr_cnt = step ? 8'd0 : corr_inc;
            st.ratio    = ratio_f;
        end
    end

    always_comb begin
        if (code_ok) begin
            o_state           = st;
            o_result.ratio    = st.ratio;
            o_result.trend    = st.trend;
            o_result.bad_code = 1'b0;
        end else begin
            // bad setting code leaves all state untouched
            o_state           = i_state;
            o_result.ratio    = 8'd0;
            o_result.trend    = TREND_NEUTRAL;
            o_result.bad_code = 1'b1;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/conductivity_ratio_trim_top.sv]
// top level of the conductivity driven acid ratio trim
//
// input channel: i_valid / o_ready carry one conductivity sample word per tick
// output channel: o_valid / i_ready carry ratio, trend and bad_code words
// every accepted sample yields exactly one result word, in order
// the result is registered and shows in the cycle after acceptance
// throughput: one sample per cycle, set by the single result register;
//   a sample is taken whenever that register is empty or being drained
// a stalled receiver holds the result and backs up the input channel
// config: i_cfg_we writes register i_cfg_idx from i_cfg_data;
//   0 target code, 1 approach margin, 2 correction period, 3 deadband,
//   4 trend window; other indexes are ignored
// reset (synchronous, active low) loads the default settings, clears the
//   trim state and empties the result register
// an invalid target code gives ratio 0, trend 0 and bad_code set, no state change
`timescale 1ns / 1ps
`default_nettype none
module conductivity_ratio_trim_top
    import crt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_conductivity,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_ratio,
    output logic [1:0]       o_trend,
    output logic             o_bad_code,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [9:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    take;

    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;

    crt_core u_core (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_conductivity (i_conductivity),
        .o_state        (n_state),
        .o_result       (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_code <= 8'd120;
            r_cfg.margin      <= 10'd120;
            r_cfg.period      <= 8'd60;
            r_cfg.deadband    <= 8'd3;
            r_cfg.window      <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET_CODE: r_cfg.target_code <= i_cfg_data[7:0];
                CFG_MARGIN:      r_cfg.margin      <= i_cfg_data;
                CFG_PERIOD:      r_cfg.period      <= i_cfg_data[7:0];
                CFG_DEADBAND:    r_cfg.deadband    <= i_cfg_data[7:0];
                CFG_WINDOW:      r_cfg.window      <= i_cfg_data[7:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_state <= n_state;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word needs no reset
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_ratio    = r_res.ratio;
    assign o_trend    = r_res.trend;
    assign o_bad_code = r_res.bad_code;

endmodule
`default_nettype wire

[hw/rtl/crt_checker.sv]
// port level checks for the conductivity ratio trim, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module crt_checker
    import crt_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [7:0]  o_ratio,
    input wire logic [1:0]  o_trend,
    input wire logic        o_bad_code
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_ratio) && $stable(o_trend)
            && $stable(o_bad_code))
        else $error("stalled result changed");

    // bad code words carry zero ratio and neutral trend
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_code |-> o_ratio == 8'd0 && o_trend == TREND_NEUTRAL)
        else $error("bad code word not zeroed");

    // a good code always yields a loaded, nonzero ratio
    a_ratio_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bad_code |-> o_ratio != 8'd0)
        else $error("zero ratio on good code");

    // a full result register that is not drained blocks the input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input accepted while result stalled");

endmodule

bind conductivity_ratio_trim_top crt_checker u_crt_checker (.*);
`default_nettype wire

[dv/conductivity_ratio_trim_top_test.sv]
// self-checking testbench for conductivity_ratio_trim_top
`timescale 1ns / 1ps
module conductivity_ratio_trim_top_test;
    import crt_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_conductivity = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_ratio;
    logic [1:0]  o_trend;
    logic        o_bad_code;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [9:0]  i_cfg_data = '0;

    conductivity_ratio_trim_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_conductivity (i_conductivity),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_ratio        (o_ratio),
        .o_trend        (o_trend),
        .o_bad_code     (o_bad_code),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    int unsigned goal_tab [26] = '{
        1280, 1290, 1300, 1310, 1320, 1330, 1340, 1350, 1360, 1370,
        1380, 1390, 1400, 1420, 1430, 1440, 1450, 1458, 1465, 1475,
        1480, 1483, 1490, 1495, 1500, 1505
    };
    logic [7:0] base_tab [26] = '{
        242, 239, 235, 232, 229, 226, 223, 220, 217, 214,
        211, 208, 205, 202, 199, 196, 194, 192, 190, 189,
        187, 186, 183, 182, 181, 180
    };

    // settings as the block should hold them
    logic [7:0]  code_reg     = 8'd120;
    logic [9:0]  margin_reg   = 10'd120;
    logic [7:0]  period_reg   = 8'd60;
    logic [7:0]  deadband_reg = 8'd3;
    logic [7:0]  window_reg   = 8'd10;

    // trim state as the block should hold it
    logic        st_started = 1'b0;
    logic [7:0]  st_ratio   = '0;
    logic [7:0]  st_corr    = '0;
    logic [7:0]  st_win     = '0;
    logic [15:0] st_ref     = '0;
    logic [1:0]  st_trend   = TREND_NEUTRAL;

    t_result trim_due [$];
    int      mismatches = 0;
    bit      steady = 1'b0;
    int      sent = 0;

    function automatic t_result next_trim(input logic [15:0] c);
        t_result     r;
        int unsigned row;
        int unsigned goal;
        logic [7:0]  base_ratio;
        r = '0;
        if (code_reg < CODE_FIRST || code_reg > CODE_LAST) begin
            r.bad_code = 1'b1;
            return r;
        end
        row = code_reg - CODE_FIRST;
        goal = goal_tab[row];
        base_ratio = base_tab[row];
        if (!st_started) begin
            st_ratio = base_ratio;
            st_started = 1'b1;
        end
        if (int'(c) + int'(margin_reg) > int'(goal)) begin
            st_win = st_win + 8'd1;
            if (st_ref > c) begin
                st_trend = TREND_UP;
            end else if (st_ref < c) begin
                st_trend = TREND_DOWN;
            end else begin
                st_trend = TREND_NEUTRAL;
            end
            if (st_win >= window_reg) begin
                st_win = '0;
                st_ref = c;
            end
            st_corr = st_corr + 8'd1;
            if (st_corr == period_reg) begin
                st_corr = '0;
                if (st_trend == TREND_UP) begin
                    if (int'(c) > int'(goal) + int'(deadband_reg) && st_ratio < RATIO_MAX)
                        st_ratio = st_ratio + 8'd1;
                end else if (st_trend == TREND_DOWN) begin
                    if (int'(c) + int'(deadband_reg) < int'(goal))
                        st_ratio = st_ratio - 8'd1;
                end
            end
            if (st_ratio == '0)
                st_ratio = base_ratio;
        end
        r.ratio = st_ratio;
        r.trend = st_trend;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 8'd0;
        if (roll < 10)
            return 8'd255;
        if (roll < 80)
            return 8'($urandom_range(1, 8));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic int goal_now();
        if (code_reg < CODE_FIRST || code_reg > CODE_LAST)
            return 1400;
        return goal_tab[code_reg - CODE_FIRST];
    endfunction

    task automatic push_sample(input int c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_conductivity <= 16'(c);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        trim_due.push_back(next_trim(16'(c)));
        sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (trim_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input int data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 10'(data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TARGET_CODE: code_reg = 8'(data);
            CFG_MARGIN:      margin_reg = 10'(data);
            CFG_PERIOD:      period_reg = 8'(data);
            CFG_DEADBAND:    deadband_reg = 8'(data);
            CFG_WINDOW:      window_reg = 8'(data);
            default: ;
        endcase
    endtask

    // result words against the predicted queue
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (trim_due.size() == 0) begin
                $error("result word with no sample pending: ratio %0d", o_ratio);
                mismatches++;
            end else begin
                want = trim_due.pop_front();
                if (o_ratio !== want.ratio) begin
                    $error("ratio: expected %0d, got %0d", want.ratio, o_ratio);
                    mismatches++;
                end
                if (o_trend !== want.trend) begin
                    $error("trend: expected %0d, got %0d", want.trend, o_trend);
                    mismatches++;
                end
                if (o_bad_code !== want.bad_code) begin
                    $error("bad_code: expected %0d, got %0d", want.bad_code, o_bad_code);
                    mismatches++;
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                i_ready <= 1'b0;
                hold--;
            end else begin
                i_ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    // invalid codes before the first good tick must leave started clear
    task automatic check_bad_codes();
        set_reg(3'(CFG_WINDOW + 3'($urandom_range(1, 3))), $urandom_range(0, 1023));
        set_reg(CFG_TARGET_CODE, CODE_FIRST - 8'd1);
        push_sample(1300);
        push_sample(65535);
        settle();
        set_reg(CFG_TARGET_CODE, CODE_LAST + 8'd1);
        push_sample(0);
        settle();
        set_reg(CFG_TARGET_CODE, 8'hFF);
        push_sample($urandom_range(0, 65535));
        settle();
        set_reg(CFG_TARGET_CODE, 0);
        push_sample(1500);
        settle();
        set_reg(CFG_TARGET_CODE, CODE_FIRST);
    endtask

    // default settings: base load, margin edge, idle tick keeps trend
    task automatic check_power_up();
        push_sample(0);
        push_sample(1160);
        push_sample(1161);
        push_sample(1161);
        push_sample(65535);
        push_sample(0);
        settle();
    endtask

    task automatic check_ratio_moves();
        set_reg(CFG_TARGET_CODE, CODE_LAST);
        set_reg(CFG_MARGIN, 1023);
        set_reg(CFG_PERIOD, 1);
        set_reg(CFG_WINDOW, 1);
        set_reg(CFG_DEADBAND, 0);
        push_sample(2000);
        push_sample(1900);
        push_sample(1506);
        push_sample(1505);
        push_sample(1505);
        push_sample(600);
        push_sample(601);
        push_sample(1504);
        push_sample(1505);
        settle();
        set_reg(CFG_DEADBAND, 255);
        set_reg(CFG_PERIOD, 0);
        set_reg(CFG_WINDOW, 0);
        push_sample(1000);
        push_sample(1200);
        push_sample(1800);
        push_sample(1700);
        settle();
    endtask

    // long well-formed ramps: climb to saturation, then walk down past zero
    task automatic check_long_ramps();
        int c;
        int goal;
        set_reg(CFG_TARGET_CODE, CODE_FIRST);
        set_reg(CFG_MARGIN, 1023);
        set_reg(CFG_PERIOD, 1);
        set_reg(CFG_WINDOW, $urandom_range(0, 1));
        set_reg(CFG_DEADBAND, $urandom_range(0, 4));
        goal = goal_now();
        c = 65535;
        while (c > goal + 300) begin
            if ($urandom_range(0, 11) == 0) begin
                push_sample($urandom_range(0, 65535));
            end else begin
                push_sample(c);
                c = c - $urandom_range(60, 260);
            end
        end
        settle();
        set_reg(CFG_TARGET_CODE, CODE_LAST);
        set_reg(CFG_WINDOW, $urandom_range(0, 1));
        set_reg(CFG_DEADBAND, $urandom_range(0, 4));
        goal = goal_now();
        c = goal - 1023 + 1;
        while (c < goal - int'(deadband_reg)) begin
            if ($urandom_range(0, 11) == 0) begin
                push_sample(c + $urandom_range(0, 40) - 20);
            end else begin
                push_sample(c);
                c = c + $urandom_range(1, 3);
            end
        end
        settle();
    endtask

    task automatic check_random_mix(input int quota);
        int stop_at;
        int n;
        int c;
        int roll;
        int goal;
        c = 0;
        stop_at = sent + quota;
        while (sent < stop_at) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                set_reg(CFG_TARGET_CODE, $urandom_range(0, 255));
            else
                set_reg(CFG_TARGET_CODE, CODE_FIRST + $urandom_range(0, 25));
            roll = $urandom_range(0, 9);
            set_reg(CFG_MARGIN, roll == 0 ? 0 : roll == 1 ? 1023 : $urandom_range(0, 1023));
            set_reg(CFG_PERIOD, pick_count());
            set_reg(CFG_WINDOW, pick_count());
            roll = $urandom_range(0, 9);
            set_reg(CFG_DEADBAND, roll == 0 ? 0 : roll == 1 ? 255 :
                    roll < 7 ? $urandom_range(0, 20) : $urandom_range(0, 255));
            goal = goal_now();
            n = $urandom_range(20, 80);
            repeat (n) begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    c = goal + $urandom_range(0, 600) - 300;
                else if (roll < 60)
                    c = goal - int'(margin_reg) + $urandom_range(0, 4) - 2;
                else if (roll < 75)
                    c = c;
                else if (roll < 90)
                    c = $urandom_range(0, 65535);
                else
                    c = $urandom_range(0, 1) ? 65535 : 0;
                if (c < 0)
                    c = 0;
                if (c > 65535)
                    c = 65535;
                push_sample(c);
            end
            settle();
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_bad_codes();
        check_power_up();
        check_ratio_moves();
        check_long_ramps();
        check_random_mix(560);
        settle();
        if (mismatches == 0) begin
            $display("conductivity_ratio_trim_top regression: pass");
        end else begin
            $display("conductivity_ratio_trim_top regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("conductivity_ratio_trim_top regression: fail");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/crt_pkg.sv
hw/rtl/crt_core.sv
hw/rtl/conductivity_ratio_trim_top.sv
hw/rtl/crt_checker.sv
dv/conductivity_ratio_trim_top_test.sv
